// ===== rtl/bbi_pkg.sv =====
// shared constants for the eight-lane block biquad filter
package bbi_pkg;

  // lanes per block and matrix columns (two output history, two input history, eight samples)
  localparam int LANES = 8;
  localparam int COLS = 12;
  localparam int HIST_COLS = 2;
  localparam int FF_COLS = COLS - HIST_COLS;
  localparam int PAIRS = FF_COLS / 2;
  localparam int NCOEF = COLS * LANES;
  localparam int IDX_W = $clog2(NCOEF);

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_BLOCK = 1'b1;

endpackage

// ===== rtl/bbi_coef_bank.sv =====
// coefficient register bank, one register per matrix entry, cleared at reset
module bbi_coef_bank #(
  parameter int COEF_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [bbi_pkg::IDX_W-1:0]           wr_idx,
  input  logic signed [COEF_WIDTH-1:0]        wr_val,
  output logic signed [COEF_WIDTH-1:0]        coef [bbi_pkg::NCOEF]
);

  // single write port, writes past the last entry are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bbi_pkg::NCOEF; k++) begin
        coef[k] <= '0;
      end
    end else if (wr_en && (wr_idx < bbi_pkg::IDX_W'(bbi_pkg::NCOEF))) begin
      coef[wr_idx] <= wr_val;
    end
  end

endmodule

// ===== rtl/bbi_ffwd.sv =====
// feed-forward part: products of input history and samples, then a two-level adder tree
module bbi_ffwd #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]          vec [bbi_pkg::FF_COLS],
  input  logic signed [COEF_WIDTH-1:0]            coef [bbi_pkg::NCOEF],
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_WIDTH+COEF_WIDTH+3:0] part [bbi_pkg::LANES],
  output logic signed [COEF_WIDTH-1:0]            rc0 [bbi_pkg::LANES],
  output logic signed [COEF_WIDTH-1:0]            rc1 [bbi_pkg::LANES]
);

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int PAIR_W = PW + 1;
  localparam int ACC_W = PW + 4;

  logic p_valid, a_valid, s_valid;
  logic p_ready, a_ready, s_ready;

  logic signed [PW-1:0]         prod_next [bbi_pkg::LANES][bbi_pkg::FF_COLS];
  logic signed [PW-1:0]         prod [bbi_pkg::LANES][bbi_pkg::FF_COLS];
  logic signed [COEF_WIDTH-1:0] p_c0 [bbi_pkg::LANES];
  logic signed [COEF_WIDTH-1:0] p_c1 [bbi_pkg::LANES];

  logic signed [PAIR_W-1:0]     pair_next [bbi_pkg::LANES][bbi_pkg::PAIRS];
  logic signed [PAIR_W-1:0]     pair [bbi_pkg::LANES][bbi_pkg::PAIRS];
  logic signed [COEF_WIDTH-1:0] a_c0 [bbi_pkg::LANES];
  logic signed [COEF_WIDTH-1:0] a_c1 [bbi_pkg::LANES];

  logic signed [ACC_W-1:0]      sum_next [bbi_pkg::LANES];

  // stall chain: a stage takes new data when empty or when it drains
  assign s_ready  = !s_valid || out_ready;
  assign a_ready  = !a_valid || s_ready;
  assign p_ready  = !p_valid || a_ready;
  assign in_ready = p_ready;
  assign out_valid = s_valid;

  // one product per lane and column
  always_comb begin
    for (int j = 0; j < bbi_pkg::LANES; j++) begin
      for (int i = 0; i < bbi_pkg::FF_COLS; i++) begin
        prod_next[j][i] = PW'(vec[i]) *
                          PW'(coef[bbi_pkg::LANES * (i + bbi_pkg::HIST_COLS) + j]);
      end
    end
  end

  // first adder level: pairs of products
  always_comb begin
    for (int j = 0; j < bbi_pkg::LANES; j++) begin
      for (int k = 0; k < bbi_pkg::PAIRS; k++) begin
        pair_next[j][k] = PAIR_W'(prod[j][2 * k]) + PAIR_W'(prod[j][2 * k + 1]);
      end
    end
  end

  // second adder level: all pairs of a lane
  always_comb begin
    for (int j = 0; j < bbi_pkg::LANES; j++) begin
      sum_next[j] = '0;
      for (int k = 0; k < bbi_pkg::PAIRS; k++) begin
        sum_next[j] = sum_next[j] + ACC_W'(pair[j][k]);
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      a_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (p_ready) p_valid <= in_valid;
      if (a_ready) a_valid <= p_valid;
      if (s_ready) s_valid <= a_valid;
    end
  end

  // product stage, history coefficients are captured with the item
  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      prod <= prod_next;
      for (int j = 0; j < bbi_pkg::LANES; j++) begin
        p_c0[j] <= coef[j];
        p_c1[j] <= coef[bbi_pkg::LANES + j];
      end
    end
  end

  // pair stage
  always_ff @(posedge clk) begin
    if (a_ready && p_valid) begin
      pair <= pair_next;
      a_c0 <= p_c0;
      a_c1 <= p_c1;
    end
  end

  // lane sum stage
  always_ff @(posedge clk) begin
    if (s_ready && a_valid) begin
      part <= sum_next;
      rc0  <= a_c0;
      rc1  <= a_c1;
    end
  end

endmodule

// ===== rtl/bbi_recur.sv =====
// recursive part: output history terms, rounding, saturation, result register
module bbi_recur #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH = 32,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [SAMPLE_WIDTH+COEF_WIDTH+3:0] part [bbi_pkg::LANES],
  input  logic signed [COEF_WIDTH-1:0]              rc0 [bbi_pkg::LANES],
  input  logic signed [COEF_WIDTH-1:0]              rc1 [bbi_pkg::LANES],
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]            y [bbi_pkg::LANES],
  output logic                                      saturated
);

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W = PW + 4;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
  localparam logic signed [SAMPLE_WIDTH-1:0] YMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] YMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  // last block's two newest outputs
  logic signed [SAMPLE_WIDTH-1:0] hy_older, hy_newer;

  logic signed [PW-1:0]           m0 [bbi_pkg::LANES];
  logic signed [PW-1:0]           m1 [bbi_pkg::LANES];
  logic signed [ACC_W-1:0]        acc [bbi_pkg::LANES];
  logic signed [ACC_W-1:0]        shifted [bbi_pkg::LANES];
  logic signed [SAMPLE_WIDTH-1:0] y_next [bbi_pkg::LANES];
  logic                           sat_next;

  assign in_ready = !out_valid || !out_stall;

  // add history terms, round half up, clamp to the sample range
  always_comb begin
    sat_next = 1'b0;
    for (int j = 0; j < bbi_pkg::LANES; j++) begin
      m0[j] = PW'(rc0[j]) * PW'(hy_older);
      m1[j] = PW'(rc1[j]) * PW'(hy_newer);
      acc[j] = part[j] + ACC_W'(m0[j]) + ACC_W'(m1[j]) + HALF;
      shifted[j] = acc[j] >>> COEF_FRAC_BITS;
      if (shifted[j] > SMAX) begin
        y_next[j] = YMAX;
        sat_next = 1'b1;
      end else if (shifted[j] < SMIN) begin
        y_next[j] = YMIN;
        sat_next = 1'b1;
      end else begin
        y_next[j] = shifted[j][SAMPLE_WIDTH-1:0];
      end
    end
  end

  // result valid and output history
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hy_older  <= '0;
      hy_newer  <= '0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        hy_older <= y_next[bbi_pkg::LANES - 2];
        hy_newer <= y_next[bbi_pkg::LANES - 1];
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      y         <= y_next;
      saturated <= sat_next;
    end
  end

endmodule

// ===== rtl/block_biquad_iir_8_lane.sv =====
// top level of the eight-lane block biquad filter in matrix form
// a block goes through the input, product, pair, lane sum and result registers
// throughput: one transaction per cycle while in_stall is low; the loop through
//   the result stage (two history multiplies, add, round, clamp) sets the clock
// coefficient writes retire in the input stage and return no result
// synchronous reset clears coefficients, sample history and all valids
module block_biquad_iir_8_lane #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH = 32,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic [bbi_pkg::IDX_W-1:0]        coef_index,
  input  logic signed [COEF_WIDTH-1:0]     coef_value,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_0,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_1,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_2,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_3,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_4,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_5,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_6,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_7,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   y_0,
  output logic signed [SAMPLE_WIDTH-1:0]   y_1,
  output logic signed [SAMPLE_WIDTH-1:0]   y_2,
  output logic signed [SAMPLE_WIDTH-1:0]   y_3,
  output logic signed [SAMPLE_WIDTH-1:0]   y_4,
  output logic signed [SAMPLE_WIDTH-1:0]   y_5,
  output logic signed [SAMPLE_WIDTH-1:0]   y_6,
  output logic signed [SAMPLE_WIDTH-1:0]   y_7,
  output logic                             saturated
);

  localparam int ACC_W = SAMPLE_WIDTH + COEF_WIDTH + 4;

  // input stage
  logic                           s1_valid;
  logic                           s1_ready;
  logic                           s1_action;
  logic [bbi_pkg::IDX_W-1:0]      s1_idx;
  logic signed [COEF_WIDTH-1:0]   s1_val;
  logic signed [SAMPLE_WIDTH-1:0] s1_x [bbi_pkg::LANES];

  // input history: last block's two newest samples
  logic signed [SAMPLE_WIDTH-1:0] hx_older, hx_newer;

  logic                           wr_en;
  logic                           ff_in_valid, ff_in_ready;
  logic                           ff_out_valid, rc_in_ready;
  logic signed [SAMPLE_WIDTH-1:0] vec [bbi_pkg::FF_COLS];
  logic signed [COEF_WIDTH-1:0]   coef [bbi_pkg::NCOEF];
  logic signed [ACC_W-1:0]        part [bbi_pkg::LANES];
  logic signed [COEF_WIDTH-1:0]   rc0 [bbi_pkg::LANES];
  logic signed [COEF_WIDTH-1:0]   rc1 [bbi_pkg::LANES];
  logic signed [SAMPLE_WIDTH-1:0] y [bbi_pkg::LANES];

  // a write retires here; a block moves on when the feed-forward pipe takes it
  assign wr_en       = s1_valid && (s1_action == bbi_pkg::ACT_WRITE);
  assign ff_in_valid = s1_valid && (s1_action == bbi_pkg::ACT_BLOCK);
  assign s1_ready    = !s1_valid || (s1_action == bbi_pkg::ACT_WRITE) || ff_in_ready;
  assign in_stall    = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_action <= action;
      s1_idx    <= coef_index;
      s1_val    <= coef_value;
      s1_x[0]   <= x_0;
      s1_x[1]   <= x_1;
      s1_x[2]   <= x_2;
      s1_x[3]   <= x_3;
      s1_x[4]   <= x_4;
      s1_x[5]   <= x_5;
      s1_x[6]   <= x_6;
      s1_x[7]   <= x_7;
    end
  end

  // input history follows each block as it leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hx_older <= '0;
      hx_newer <= '0;
    end else if (ff_in_valid && ff_in_ready) begin
      hx_older <= s1_x[bbi_pkg::LANES - 2];
      hx_newer <= s1_x[bbi_pkg::LANES - 1];
    end
  end

  // feed-forward vector: input history then new samples
  always_comb begin
    vec[0] = hx_older;
    vec[1] = hx_newer;
    for (int i = 0; i < bbi_pkg::LANES; i++) begin
      vec[i + bbi_pkg::HIST_COLS] = s1_x[i];
    end
  end

  bbi_coef_bank #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_idx (s1_idx),
    .wr_val (s1_val),
    .coef   (coef)
  );

  bbi_ffwd #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_ffwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ff_in_valid),
    .in_ready  (ff_in_ready),
    .vec       (vec),
    .coef      (coef),
    .out_valid (ff_out_valid),
    .out_ready (rc_in_ready),
    .part      (part),
    .rc0       (rc0),
    .rc1       (rc1)
  );

  bbi_recur #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_recur (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ff_out_valid),
    .in_ready  (rc_in_ready),
    .part      (part),
    .rc0       (rc0),
    .rc1       (rc1),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .y         (y),
    .saturated (saturated)
  );

  assign y_0 = y[0];
  assign y_1 = y[1];
  assign y_2 = y[2];
  assign y_3 = y[3];
  assign y_4 = y[4];
  assign y_5 = y[5];
  assign y_6 = y[6];
  assign y_7 = y[7];

endmodule

// ===== rtl/bbi_checker.sv =====
// port-level checker for the block biquad filter, bound to the top level
module bbi_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [SAMPLE_WIDTH-1:0] y_0,
  input logic signed [SAMPLE_WIDTH-1:0] y_1,
  input logic signed [SAMPLE_WIDTH-1:0] y_2,
  input logic signed [SAMPLE_WIDTH-1:0] y_3,
  input logic signed [SAMPLE_WIDTH-1:0] y_4,
  input logic signed [SAMPLE_WIDTH-1:0] y_5,
  input logic signed [SAMPLE_WIDTH-1:0] y_6,
  input logic signed [SAMPLE_WIDTH-1:0] y_7,
  input logic                           saturated
);

  localparam logic signed [SAMPLE_WIDTH-1:0] YMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] YMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] yv [bbi_pkg::LANES];
  logic                           any_extreme;

  assign yv[0] = y_0;
  assign yv[1] = y_1;
  assign yv[2] = y_2;
  assign yv[3] = y_3;
  assign yv[4] = y_4;
  assign yv[5] = y_5;
  assign yv[6] = y_6;
  assign yv[7] = y_7;

  // some lane sits at a rail of the sample range
  always_comb begin
    any_extreme = 1'b0;
    for (int k = 0; k < bbi_pkg::LANES; k++) begin
      if ((yv[k] == YMAX) || (yv[k] == YMIN)) any_extreme = 1'b1;
    end
  end

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // with nothing waiting at the output every stage drains, so input is open
  a_open_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(y_0) && $stable(y_1) &&
      $stable(y_2) && $stable(y_3) && $stable(y_4) && $stable(y_5) &&
      $stable(y_6) && $stable(y_7) && $stable(saturated))
    else $error("stalled result changed");

  // a clipped transaction shows at least one lane on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> any_extreme)
    else $error("saturation flag without clipped lane");

endmodule

bind block_biquad_iir_8_lane bbi_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bbi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .y_0       (y_0),
  .y_1       (y_1),
  .y_2       (y_2),
  .y_3       (y_3),
  .y_4       (y_4),
  .y_5       (y_5),
  .y_6       (y_6),
  .y_7       (y_7),
  .saturated (saturated)
);

// ===== tb/sv/tb_block_biquad_iir_8_lane.sv =====
// self-checking testbench for the eight-lane block biquad filter
`timescale 1ns / 100ps

module tb_block_biquad_iir_8_lane;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 32;
  localparam int COEF_FRAC = 24;
  localparam int DUT_LATENCY = 5;
  localparam int HOLD_CYCLES = 80;
  localparam longint ROUND_HALF = longint'(1) << (COEF_FRAC - 1);
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic [COEF_W-1:0] COEF_ONE = 32'h0100_0000;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'h0080_0000;
  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7fff_ffff;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

  // one input transaction
  typedef struct packed {
    logic                                    act;
    logic [bbi_pkg::IDX_W-1:0]               idx;
    logic [COEF_W-1:0]                       cval;
    logic [bbi_pkg::LANES-1:0][SAMPLE_W-1:0] x;
  } biquad_item_t;

  // one output transaction
  typedef struct packed {
    logic [bbi_pkg::LANES-1:0][SAMPLE_W-1:0] y;
    logic                                    sat;
  } block_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = bbi_pkg::ACT_WRITE;
  logic [bbi_pkg::IDX_W-1:0] coef_index = '0;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic signed [SAMPLE_W-1:0] x_0 = '0;
  logic signed [SAMPLE_W-1:0] x_1 = '0;
  logic signed [SAMPLE_W-1:0] x_2 = '0;
  logic signed [SAMPLE_W-1:0] x_3 = '0;
  logic signed [SAMPLE_W-1:0] x_4 = '0;
  logic signed [SAMPLE_W-1:0] x_5 = '0;
  logic signed [SAMPLE_W-1:0] x_6 = '0;
  logic signed [SAMPLE_W-1:0] x_7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] y_0, y_1, y_2, y_3, y_4, y_5, y_6, y_7;
  logic saturated;

  // shadow filter state
  logic signed [COEF_W-1:0] coef_shadow [bbi_pkg::NCOEF];
  logic signed [SAMPLE_W-1:0] hist_y_older = '0;
  logic signed [SAMPLE_W-1:0] hist_y_newer = '0;
  logic signed [SAMPLE_W-1:0] hist_x_older = '0;
  logic signed [SAMPLE_W-1:0] hist_x_newer = '0;

  block_result_t expected_blocks [$];
  int err_count = 0;
  int blocks_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_active = 1'b0;
  event hold_go;

  block_biquad_iir_8_lane i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .x_0        (x_0),
    .x_1        (x_1),
    .x_2        (x_2),
    .x_3        (x_3),
    .x_4        (x_4),
    .x_5        (x_5),
    .x_6        (x_6),
    .x_7        (x_7),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .y_0        (y_0),
    .y_1        (y_1),
    .y_2        (y_2),
    .y_3        (y_3),
    .y_4        (y_4),
    .y_5        (y_5),
    .y_6        (y_6),
    .y_7        (y_7),
    .saturated  (saturated)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // apply one accepted transaction to the shadow state, queue the block output
  function automatic void filter_item(input biquad_item_t it);
    longint col_val [bbi_pkg::COLS];
    longint acc;
    longint r;
    block_result_t res;
    if (it.act == bbi_pkg::ACT_WRITE) begin
      if (it.idx < bbi_pkg::NCOEF)
        coef_shadow[it.idx] = it.cval;
      return;
    end
    col_val[0] = longint'(hist_y_older);
    col_val[1] = longint'(hist_y_newer);
    col_val[2] = longint'(hist_x_older);
    col_val[3] = longint'(hist_x_newer);
    for (int k = 0; k < bbi_pkg::LANES; k++)
      col_val[k + 4] = longint'($signed(it.x[k]));
    res.sat = 1'b0;
    for (int j = 0; j < bbi_pkg::LANES; j++) begin
      acc = 0;
      for (int i = 0; i < bbi_pkg::COLS; i++)
        acc += longint'(coef_shadow[bbi_pkg::LANES * i + j]) * col_val[i];
      // round half up, then clamp to the sample range
      r = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (r > SAMPLE_MAX) begin
        r = SAMPLE_MAX;
        res.sat = 1'b1;
      end else if (r < SAMPLE_MIN) begin
        r = SAMPLE_MIN;
        res.sat = 1'b1;
      end
      res.y[j] = r[SAMPLE_W-1:0];
    end
    hist_y_older = res.y[bbi_pkg::LANES - 2];
    hist_y_newer = res.y[bbi_pkg::LANES - 1];
    hist_x_older = it.x[bbi_pkg::LANES - 2];
    hist_x_newer = it.x[bbi_pkg::LANES - 1];
    expected_blocks.push_back(res);
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_item(input biquad_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= it.act;
    coef_index <= it.idx;
    coef_value <= it.cval;
    x_0 <= it.x[0];
    x_1 <= it.x[1];
    x_2 <= it.x[2];
    x_3 <= it.x[3];
    x_4 <= it.x[4];
    x_5 <= it.x[5];
    x_6 <= it.x[6];
    x_7 <= it.x[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_item(it);
  endtask

  // stop sending and wait for every queued block output
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 3) @(posedge clk);
  endtask

  function automatic biquad_item_t make_write(input int idx, input logic [COEF_W-1:0] val);
    biquad_item_t it;
    it.act = bbi_pkg::ACT_WRITE;
    it.idx = idx[bbi_pkg::IDX_W-1:0];
    it.cval = val;
    for (int k = 0; k < bbi_pkg::LANES; k++)
      it.x[k] = SAMPLE_W'($urandom);
    return it;
  endfunction

  // block transaction with zero samples; coefficient fields are don't-care
  function automatic biquad_item_t make_block();
    biquad_item_t it;
    it.act = bbi_pkg::ACT_BLOCK;
    it.idx = bbi_pkg::IDX_W'($urandom);
    it.cval = $urandom;
    it.x = '0;
    return it;
  endfunction

  function automatic biquad_item_t rand_item();
    biquad_item_t it;
    it.act = ($urandom_range(99, 0) < 80) ? bbi_pkg::ACT_BLOCK : bbi_pkg::ACT_WRITE;
    if ($urandom_range(9, 0) == 0)
      it.idx = bbi_pkg::IDX_W'($urandom_range(127, bbi_pkg::NCOEF));
    else
      it.idx = bbi_pkg::IDX_W'($urandom_range(bbi_pkg::NCOEF - 1, 0));
    case ($urandom_range(3, 0))
      0: it.cval = $urandom;
      1: it.cval = $urandom_range(2 * COEF_ONE, 0) - COEF_ONE;
      default: it.cval = $urandom_range(4194303, 0) - 2097152;
    endcase
    for (int k = 0; k < bbi_pkg::LANES; k++) begin
      case ($urandom_range(15, 0))
        0: it.x[k] = 16'h7fff;
        1: it.x[k] = 16'h8000;
        default: it.x[k] = SAMPLE_W'($urandom);
      endcase
    end
    return it;
  endfunction

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_active)
      out_stall <= 1'b1;
    else
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // hold-off length counted here
  initial begin
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // compare each output transaction with the oldest queued block
  always @(posedge clk) begin : result_check
    block_result_t got_res;
    block_result_t want_res;
    if (!rst && out_valid && !out_stall) begin
      got_res.y = {y_7, y_6, y_5, y_4, y_3, y_2, y_1, y_0};
      got_res.sat = saturated;
      if (expected_blocks.size() == 0) begin
        report_mismatch("output transaction with no block pending");
      end else begin
        want_res = expected_blocks.pop_front();
        for (int j = 0; j < bbi_pkg::LANES; j++) begin
          if (got_res.y[j] !== want_res.y[j])
            report_mismatch($sformatf("block %0d y_%0d got %0d expected %0d", blocks_seen, j,
                                      $signed(got_res.y[j]), $signed(want_res.y[j])));
        end
        if (got_res.sat !== want_res.sat)
          report_mismatch($sformatf("block %0d saturated got %b expected %b", blocks_seen,
                                    got_res.sat, want_res.sat));
      end
      blocks_seen++;
    end
  end

  // zero coefficients after reset give zero outputs
  task automatic test_zero_coefs();
    biquad_item_t it;
    it = make_block();
    it.x = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff};
    send_item(it);
  endtask

  // pass-through diagonal, then out-of-range writes that must not land
  task automatic test_identity_and_bad_index();
    biquad_item_t it;
    for (int j = 0; j < bbi_pkg::LANES; j++)
      send_item(make_write(bbi_pkg::LANES * (j + 4) + j, COEF_ONE));
    it = make_block();
    it.x = {16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h1234};
    send_item(it);
    send_item(make_write(bbi_pkg::NCOEF, COEF_MAX));
    send_item(make_write(127, COEF_MIN));
    it = make_block();
    it.x = {16'h0100, 16'hff00, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h4000, 16'hc000};
    send_item(it);
  endtask

  // half-weight coefficient exercises the round-half-up ties
  task automatic test_rounding_ties();
    biquad_item_t it;
    send_item(make_write(bbi_pkg::LANES * 5 + 3, COEF_HALF));
    it = make_block();
    it.x[1] = 16'h0001;
    send_item(it);
    it = make_block();
    it.x[1] = 16'hffff;
    send_item(it);
  endtask

  // extreme coefficients clip both ways; rail values feed back as history
  task automatic test_saturation();
    biquad_item_t it;
    send_item(make_write(bbi_pkg::LANES * 0 + 0, COEF_MAX));
    send_item(make_write(bbi_pkg::LANES * 1 + 1, COEF_MIN));
    send_item(make_write(bbi_pkg::LANES * 4 + 2, COEF_MAX));
    it = make_block();
    it.x = {16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff};
    send_item(it);
    it = make_block();
    it.x[0] = 16'h8000;
    send_item(it);
    it = make_block();
    send_item(it);
  endtask

  task automatic test_random_traffic(input int n, input int spct, input int rpct);
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    repeat (n) send_item(rand_item());
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_go;
    repeat (50) send_item(rand_item());
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < bbi_pkg::NCOEF; k++)
      coef_shadow[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_coefs();
    test_identity_and_bad_index();
    test_rounding_ties();
    test_saturation();
    wait_drained();
    test_random_traffic(160, 33, 53);
    test_random_traffic(160, 53, 33);
    test_random_traffic(160, 0, 0);
    test_backpressure();

    if (expected_blocks.size() != 0)
      report_mismatch($sformatf("%0d block outputs never arrived", expected_blocks.size()));
    if (err_count == 0)
      $display("** block_biquad_iir_8_lane: PASSED **");
    else
      $display("** block_biquad_iir_8_lane: FAILED **");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("** block_biquad_iir_8_lane: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bbi_pkg.sv
rtl/bbi_coef_bank.sv
rtl/bbi_ffwd.sv
rtl/bbi_recur.sv
rtl/block_biquad_iir_8_lane.sv
rtl/bbi_checker.sv
tb/sv/tb_block_biquad_iir_8_lane.sv
